FILE: hw/rtl/ece_pkg.sv
package ece_pkg;

    localparam int ECE_MAX_NODES = 16;
    localparam int STATE_W       = 4;
    localparam int ROW_W         = 16;
    localparam int CFG_W         = 5;

    // Commands from the sequencer to the row store.
    typedef struct packed {
        logic               load;   // write one successor row
        logic               init;   // mask rows to the state count, add the self bit
        logic               step;   // one Warshall pivot over all rows
        logic               clear;  // wipe the store after a run
        logic [STATE_W-1:0] sel;    // pivot row or row to read out
        logic [STATE_W:0]   n;      // states in use, 1..rows
    } t_mat_ctrl;

endpackage

FILE: hw/rtl/ece_matrix.sv
module ece_matrix #(
    parameter int MAX_NODES = ece_pkg::ECE_MAX_NODES,
    localparam int Rows = (MAX_NODES < ece_pkg::ROW_W) ? MAX_NODES : ece_pkg::ROW_W,
    localparam int IdxW = $clog2(Rows)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ece_pkg::t_mat_ctrl             i_ctrl,
    input  logic [ece_pkg::STATE_W-1:0]    i_wr_index,
    input  logic [ece_pkg::ROW_W-1:0]      i_wr_row,
    output logic [Rows-1:0]                o_rd_row
);
    import ece_pkg::*;

    logic [Rows-1:0] r_row [Rows];
    logic [Rows-1:0] pivot;
    logic [Rows-1:0] nmask;
    logic [IdxW-1:0] sel;

    assign sel      = i_ctrl.sel[IdxW-1:0];
    assign pivot    = r_row[sel];
    assign o_rd_row = pivot;

    always_comb begin
        for (int i = 0; i < Rows; i++) begin
            nmask[i] = ((STATE_W+1)'(i) < i_ctrl.n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Rows; i++) begin
                r_row[i] <= '0;
            end
        end else begin
            priority if (i_ctrl.clear) begin
                for (int i = 0; i < Rows; i++) begin
                    r_row[i] <= '0;
                end
            end else if (i_ctrl.init) begin
                for (int i = 0; i < Rows; i++) begin
                    if (nmask[i]) begin
                        r_row[i] <= (r_row[i] & nmask) | (Rows'(1) << i);
                    end
                end
            end else if (i_ctrl.step) begin
                // Row k is not changed by pivot k, so all rows update at once.
                for (int i = 0; i < Rows; i++) begin
                    if (r_row[i][sel]) begin
                        r_row[i] <= r_row[i] | pivot;
                    end
                end
            end else if (i_ctrl.load) begin
                if ({1'b0, i_wr_index} < (STATE_W+1)'(Rows)) begin
                    r_row[i_wr_index[IdxW-1:0]] <= i_wr_row[Rows-1:0];
                end
            end
        end
    end

endmodule

FILE: hw/rtl/ece_ctrl.sv
module ece_ctrl #(
    parameter int MAX_NODES = ece_pkg::ECE_MAX_NODES,
    localparam int Rows = (MAX_NODES < ece_pkg::ROW_W) ? MAX_NODES : ece_pkg::ROW_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_last_row,
    input  logic                           i_cfg_valid,
    input  logic [ece_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [Rows-1:0]                i_rd_row,
    output ece_pkg::t_mat_ctrl             o_ctrl,
    output logic                           o_busy,
    output logic                           o_valid,
    output logic [ece_pkg::STATE_W-1:0]    o_closure_state,
    output logic [ece_pkg::ROW_W-1:0]      o_closure_row,
    output logic                           o_closure_last
);
    import ece_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INIT,
        S_CLOSE,
        S_EMIT
    } t_state;

    t_state             r_state;
    logic [STATE_W-1:0] r_cnt;
    logic [CFG_W-1:0]   r_num_states;
    logic               r_valid;
    logic [STATE_W-1:0] r_out_state;
    logic [ROW_W-1:0]   r_out_row;
    logic               r_out_last;
    logic [STATE_W:0]   n_use;
    logic               cnt_last;

    always_comb begin
        if (r_num_states == '0) begin
            n_use = (STATE_W+1)'(1);
        end else if (r_num_states > CFG_W'(Rows)) begin
            n_use = (STATE_W+1)'(Rows);
        end else begin
            n_use = r_num_states;
        end
    end

    assign cnt_last = ({1'b0, r_cnt} == n_use - (STATE_W+1)'(1));

    always_comb begin
        o_ctrl       = '0;
        o_ctrl.n     = n_use;
        o_ctrl.sel   = r_cnt;
        o_ctrl.load  = i_start && (r_state == S_IDLE);
        o_ctrl.init  = (r_state == S_INIT);
        o_ctrl.step  = (r_state == S_CLOSE);
        o_ctrl.clear = (r_state == S_EMIT) && cnt_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_num_states <= CFG_W'(16);
            r_valid      <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_num_states <= i_cfg_data;
            end
            r_valid    <= 1'b0;
            r_out_last <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && i_last_row) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_CLOSE;
                end
                S_CLOSE: begin
                    if (cnt_last) begin
                        r_cnt   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt + STATE_W'(1);
                    end
                end
                S_EMIT: begin
                    r_valid     <= 1'b1;
                    r_out_state <= r_cnt;
                    r_out_row   <= ROW_W'(i_rd_row);
                    r_out_last  <= cnt_last;
                    if (cnt_last) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + STATE_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_closure_state = r_out_state;
    assign o_closure_row   = r_out_row;
    assign o_closure_last  = r_out_last;

endmodule

FILE: hw/rtl/epsilon_closure_engine.sv
// Row loads never stall; the block stays ready between them.
// A transaction with the last-row flag makes the block busy for a masking step, one
// Warshall pivot per state in use over all rows in parallel, and one readout per state.
// After the pivots the results come out one per cycle, and the final one comes with busy low.
// The receiver cannot stall; each result strobe lasts one cycle.
// Synchronous active-low reset clears the matrix and sets the state count to 16.
module epsilon_closure_engine #(
    parameter int MAX_NODES = ece_pkg::ECE_MAX_NODES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [ece_pkg::STATE_W-1:0]    i_state_index,
    input  logic [ece_pkg::ROW_W-1:0]      i_eps_row,
    input  logic                           i_last_row,
    output logic                           o_valid,
    output logic [ece_pkg::STATE_W-1:0]    o_closure_state,
    output logic [ece_pkg::ROW_W-1:0]      o_closure_row,
    output logic                           o_closure_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ece_pkg::CFG_W-1:0]      i_cfg_data
);
    import ece_pkg::*;

    localparam int Rows = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;

    t_mat_ctrl       mat_ctrl;
    logic [Rows-1:0] rd_row;

    assign o_cfg_ready = 1'b1;

    ece_ctrl #(
        .MAX_NODES(MAX_NODES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_last_row     (i_last_row),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_rd_row       (rd_row),
        .o_ctrl         (mat_ctrl),
        .o_busy         (o_busy),
        .o_valid        (o_valid),
        .o_closure_state(o_closure_state),
        .o_closure_row  (o_closure_row),
        .o_closure_last (o_closure_last)
    );

    ece_matrix #(
        .MAX_NODES(MAX_NODES)
    ) u_matrix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (mat_ctrl),
        .i_wr_index(i_state_index),
        .i_wr_row  (i_eps_row),
        .o_rd_row  (rd_row)
    );

    // Every result comes out of a closure pass that had the block busy.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result strobe without a preceding closure pass");

    a_last_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_closure_last |-> o_valid)
        else $error("last flag without a result strobe");

    // The closure is reflexive.
    a_self_in_closure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_closure_row[o_closure_state])
        else $error("closure row misses its own state");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_closure_last) |-> !o_busy)
        else $error("block still busy after the final result");

endmodule
